// ===== sv/assert_macros.svh =====
// Assertion macros shared by the shift engine modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds on every clock edge outside reset.
`define JMS_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// An implication checked on the same clock edge.
`define JMS_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// An implication whose consequence is checked on the next clock edge.
`define JMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/jms_pkg.sv =====
// Types, codes and helper functions of the JTAG master shift engine.
// Used by jms_front, jms_back and jtag_master_shift_engine; no dependencies.
package jms_pkg;

   localparam int QueueDepth   = 2;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);
   localparam int HalfBits     = 16;
   localparam logic [HalfBits-1:0] HalfMin = 16'd2;

   typedef enum logic [1:0] {
      CMD_SET_PINS = 2'd0,
      CMD_TMS_SEQ  = 2'd1,
      CMD_SHIFT    = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_DISABLED   = 2'd1,
      STATUS_BOTH_ENTRY = 2'd2
   } status_type;

   typedef enum logic {
      CSR_ENABLED         = 1'b0,
      CSR_TCK_HALF_PERIOD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_REPORT,
      OP_SET_PINS,
      OP_TMS_SEQ,
      OP_SHIFT
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ENTRY,
      BK_DATA,
      BK_EXIT
   } back_state_type;

   typedef struct packed {
      cmd_type    command;
      logic       nrst;
      logic       ntrst;
      logic       tdi_level;
      logic [2:0] bit_count_code;
      logic [7:0] data_byte;
      logic       enter_dr;
      logic       enter_ir;
      logic       exit_update;
      logic [7:0] target_tdo;
   } req_word_type;

   typedef struct packed {
      logic       tck_pulse;
      logic       tms;
      logic       tdi;
      logic       nrst_out;
      logic       ntrst_out;
      status_type status;
      logic [7:0] received_byte;
      logic       last;
   } rsp_word_type;

   // A classified command as handed from the front to the back.
   typedef struct packed {
      op_type     op;
      status_type status;
      logic       nrst;
      logic       ntrst;
      logic       tdi_level;
      logic [2:0] bit_code;
      logic [7:0] data;
      logic       enter_dr;
      logic       enter_ir;
      logic       exit_update;
      logic [7:0] rx;
   } plan_type;

   // Keeps the low code+1 bits of a byte.
   function automatic logic [7:0] low_bits(input logic [7:0] value, input logic [2:0] code);
      logic [7:0] mask;
      mask = 8'hFF >> (3'd7 - code);
      return value & mask;
   endfunction

endpackage

// ===== sv/jtag_master_shift_engine.sv =====
// JTAG master shift engine: top level with the control registers.
// Instantiates jms_front and jms_back; depends on jms_pkg.
//
// Usage:
//   Commands enter as req_word with req_push; a word is taken on a clock edge
//   with req_push high and req_full low. A two-entry queue of classified
//   commands sits between the front end and the pulse sequencer.
//   Results leave as rsp_word while rsp_empty is low and are taken with
//   rsp_pop. Each result is one TCK pulse (or one pin update or status
//   report), and the one that ends a command has last set.
//   Control registers are written through csr_valid/csr_ready (always ready)
//   with csr_index 0 = enabled, 1 = TCK half period (held at two or more).
//   Write them only while the engine is idle.
// Timing:
//   A command that makes no pulse has its result written to the result
//   register as the sequencer takes it from the queue. A pulsing command
//   gives 1 to 14 pulses, each a low and a high half timed by the half-period
//   counter of the sequencer, which returns to idle between commands.
//   If rsp_pop stays low the sequencer holds at the end of its next pulse
//   and the queue fills until req_full rises; nothing is dropped.
// Reset:
//   Clears the plan queue and the result register; nRST, nTRST and TDI go
//   high, TMS low, the engine is disabled and the half period is two.

module jtag_master_shift_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  jms_pkg::req_word_type        req_word,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output jms_pkg::rsp_word_type        rsp_word,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  jms_pkg::csr_index_type       csr_index,
   input  logic [jms_pkg::HalfBits-1:0] csr_data
);

   logic                         enabled_ff, enabled_in;
   logic [jms_pkg::HalfBits-1:0] half_ff, half_in;
   logic                         plan_valid;
   logic                         plan_pop;
   jms_pkg::plan_type            plan;

   assign csr_ready = 1'b1;

   always_comb begin
      enabled_in = enabled_ff;
      half_in    = half_ff;
      if (csr_valid) begin
         case (csr_index)
            jms_pkg::CSR_ENABLED: enabled_in = csr_data[0];
            jms_pkg::CSR_TCK_HALF_PERIOD:
               half_in = (csr_data < jms_pkg::HalfMin) ? jms_pkg::HalfMin : csr_data;
            default: enabled_in = enabled_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         half_ff    <= jms_pkg::HalfMin;
      end else begin
         enabled_ff <= enabled_in;
         half_ff    <= half_in;
      end
   end

   jms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enabled    (enabled_ff),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .plan_valid (plan_valid),
      .plan       (plan),
      .plan_pop   (plan_pop)
   );

   jms_back u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_ff),
      .plan_valid  (plan_valid),
      .plan        (plan),
      .plan_pop    (plan_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_word    (rsp_word)
   );

endmodule

// ===== sv/jms_front.sv =====
// Front end of the shift engine: accepts command words, classifies them and
// queues the resulting plans for the back end. Depends on jms_pkg.
`include "assert_macros.svh"

module jms_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enabled,
   input  logic                 req_push,
   output logic                 req_full,
   input  jms_pkg::req_word_type req_word,
   output logic                 plan_valid,
   output jms_pkg::plan_type    plan,
   input  logic                 plan_pop
);

   jms_pkg::plan_type                   queue_ff [jms_pkg::QueueDepth];
   logic [jms_pkg::QueuePtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [jms_pkg::QueuePtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [jms_pkg::QueueCntBits-1:0]    count_ff, count_in;
   logic                                accept;
   logic                                take;
   jms_pkg::plan_type                   classified;

   assign req_full   = (count_ff == jms_pkg::QueueCntBits'(jms_pkg::QueueDepth));
   assign accept     = req_push && !req_full;
   assign plan_valid = (count_ff != '0);
   assign take       = plan_pop && plan_valid;
   assign plan       = queue_ff[rd_ptr_ff];

   always_comb begin
      classified           = '0;
      classified.op        = jms_pkg::OP_REPORT;
      classified.status    = jms_pkg::STATUS_OK;
      classified.nrst      = req_word.nrst;
      classified.ntrst     = req_word.ntrst;
      classified.tdi_level = req_word.tdi_level;
      classified.bit_code  = req_word.bit_count_code;
      classified.data      = req_word.data_byte;
      classified.enter_dr  = req_word.enter_dr;
      classified.enter_ir  = req_word.enter_ir;
      classified.exit_update = req_word.exit_update;
      classified.rx        = jms_pkg::low_bits(req_word.target_tdo, req_word.bit_count_code);
      if (!enabled) begin
         classified.status = jms_pkg::STATUS_DISABLED;
      end else begin
         case (req_word.command)
            jms_pkg::CMD_SET_PINS: classified.op = jms_pkg::OP_SET_PINS;
            jms_pkg::CMD_TMS_SEQ:  classified.op = jms_pkg::OP_TMS_SEQ;
            jms_pkg::CMD_SHIFT: begin
               if (req_word.enter_dr && req_word.enter_ir) begin
                  classified.status = jms_pkg::STATUS_BOTH_ENTRY;
               end else begin
                  classified.op = jms_pkg::OP_SHIFT;
               end
            end
            default: classified.op = jms_pkg::OP_REPORT;
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   `JMS_ASSERT_ALWAYS(a_count_bound,
      count_ff <= jms_pkg::QueueCntBits'(jms_pkg::QueueDepth), "plan queue overfilled")
   `JMS_ASSERT_NEXT(a_count_tracks, accept && !take, count_ff == $past(count_ff) + 1'b1,
      "plan queue count did not follow a push")

endmodule

// ===== sv/jms_back.sv =====
// Back end of the shift engine: runs one plan at a time, as TCK pulses timed
// by the half-period counter or as one pin update or report, keeps the pin
// state and holds the result word. Depends on jms_pkg.
`include "assert_macros.svh"

module jms_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [jms_pkg::HalfBits-1:0]  half_period,
   input  logic                          plan_valid,
   input  jms_pkg::plan_type             plan,
   output logic                          plan_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output jms_pkg::rsp_word_type         rsp_word
);

   jms_pkg::back_state_type       state_ff, state_in;
   jms_pkg::plan_type             cur_ff, cur_in;
   logic [2:0]                    bit_ff, bit_in;
   logic [jms_pkg::HalfBits-1:0]  timer_ff, timer_in;
   logic                          hi_ff, hi_in;
   logic                          nrst_ff, nrst_in;
   logic                          ntrst_ff, ntrst_in;
   logic                          tdi_ff, tdi_in;
   logic                          tms_ff, tms_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   jms_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;
   logic [jms_pkg::HalfBits-1:0]  half_m1;
   logic                          slot_free;
   logic                          tick;
   logic                          emit;
   logic                          step_done;
   logic                          entry_end;
   logic                          data_end;
   jms_pkg::rsp_word_type         result;

   assign half_m1   = half_period - 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_pop;
   // A pulse is complete at the end of its high half.
   assign tick      = hi_ff && (timer_ff == half_m1);
   assign step_done = tick && slot_free;
   assign entry_end = (bit_ff == (cur_ff.enter_ir ? 3'd3 : 3'd2));
   assign data_end  = (bit_ff == cur_ff.bit_code);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jms_pkg::BK_IDLE: begin
            if (plan_valid && plan.op == jms_pkg::OP_TMS_SEQ) begin
               state_in = jms_pkg::BK_DATA;
            end else if (plan_valid && plan.op == jms_pkg::OP_SHIFT) begin
               state_in = (plan.enter_dr || plan.enter_ir) ? jms_pkg::BK_ENTRY
                                                           : jms_pkg::BK_DATA;
            end
         end
         jms_pkg::BK_ENTRY: begin
            if (step_done && entry_end) begin
               state_in = jms_pkg::BK_DATA;
            end
         end
         jms_pkg::BK_DATA: begin
            if (step_done && data_end) begin
               state_in = (cur_ff.op == jms_pkg::OP_SHIFT && cur_ff.exit_update)
                          ? jms_pkg::BK_EXIT : jms_pkg::BK_IDLE;
            end
         end
         jms_pkg::BK_EXIT: begin
            if (step_done && bit_ff != 3'd0) begin
               state_in = jms_pkg::BK_IDLE;
            end
         end
         default: state_in = jms_pkg::BK_IDLE;
      endcase
   end

   // Outputs, pin state and pulse timing.
   always_comb begin
      cur_in     = cur_ff;
      bit_in     = bit_ff;
      nrst_in    = nrst_ff;
      ntrst_in   = ntrst_ff;
      tdi_in     = tdi_ff;
      tms_in     = tms_ff;
      plan_pop   = 1'b0;
      emit       = 1'b0;
      result           = '0;
      result.tck_pulse = 1'b1;
      result.tms       = tms_ff;
      result.tdi       = tdi_ff;
      result.nrst_out  = nrst_ff;
      result.ntrst_out = ntrst_ff;
      result.status    = jms_pkg::STATUS_OK;
      // Half-period counter; it waits at the end of a pulse while the
      // result register is still occupied.
      timer_in = timer_ff;
      hi_in    = hi_ff;
      if (state_ff == jms_pkg::BK_IDLE || step_done) begin
         timer_in = '0;
         hi_in    = 1'b0;
      end else if (!tick) begin
         if (timer_ff == half_m1) begin
            timer_in = '0;
            hi_in    = 1'b1;
         end else begin
            timer_in = timer_ff + 1'b1;
         end
      end

      case (state_ff)
         jms_pkg::BK_IDLE: begin
            bit_in = 3'd0;
            if (plan_valid) begin
               case (plan.op)
                  jms_pkg::OP_REPORT: begin
                     if (slot_free) begin
                        plan_pop         = 1'b1;
                        emit             = 1'b1;
                        result.tck_pulse = 1'b0;
                        result.status    = plan.status;
                        result.last      = 1'b1;
                     end
                  end
                  jms_pkg::OP_SET_PINS: begin
                     if (slot_free) begin
                        plan_pop         = 1'b1;
                        emit             = 1'b1;
                        nrst_in          = plan.nrst;
                        ntrst_in         = plan.ntrst;
                        tdi_in           = plan.tdi_level;
                        result.tck_pulse = 1'b0;
                        result.tdi       = plan.tdi_level;
                        result.nrst_out  = plan.nrst;
                        result.ntrst_out = plan.ntrst;
                        result.last      = 1'b1;
                     end
                  end
                  jms_pkg::OP_TMS_SEQ: begin
                     plan_pop = 1'b1;
                     cur_in   = plan;
                     nrst_in  = plan.nrst;
                     ntrst_in = plan.ntrst;
                     tdi_in   = plan.tdi_level;
                  end
                  default: begin
                     plan_pop = 1'b1;
                     cur_in   = plan;
                  end
               endcase
            end
         end
         jms_pkg::BK_ENTRY: begin
            // IR entry clocks TMS 1,1,0,0 and DR entry 1,0,0.
            result.tms = cur_ff.enter_ir ? (bit_ff < 3'd2) : (bit_ff == 3'd0);
            if (step_done) begin
               emit   = 1'b1;
               bit_in = entry_end ? 3'd0 : bit_ff + 1'b1;
               if (entry_end) begin
                  tms_in = 1'b0;
               end
            end
         end
         jms_pkg::BK_DATA: begin
            if (cur_ff.op == jms_pkg::OP_TMS_SEQ) begin
               result.tms  = cur_ff.data[bit_ff];
               result.last = data_end;
            end else begin
               result.tdi  = cur_ff.data[bit_ff];
               result.tms  = (cur_ff.exit_update && data_end) ? 1'b1 : tms_ff;
               result.last = data_end && !cur_ff.exit_update;
               result.received_byte = result.last ? cur_ff.rx : 8'd0;
            end
            if (step_done) begin
               emit   = 1'b1;
               tms_in = result.tms;
               tdi_in = result.tdi;
               bit_in = data_end ? 3'd0 : bit_ff + 1'b1;
            end
         end
         jms_pkg::BK_EXIT: begin
            // Exit1 with TMS high, then Update with TMS low back to idle.
            result.tms = (bit_ff == 3'd0);
            if (bit_ff != 3'd0) begin
               result.last          = 1'b1;
               result.received_byte = cur_ff.rx;
            end
            if (step_done) begin
               emit   = 1'b1;
               tms_in = result.tms;
               bit_in = bit_ff + 1'b1;
            end
         end
         default: begin
            bit_in = 3'd0;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);
      rsp_word_in  = emit ? result : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jms_pkg::BK_IDLE;
         bit_ff       <= '0;
         timer_ff     <= '0;
         hi_ff        <= 1'b0;
         nrst_ff      <= 1'b1;
         ntrst_ff     <= 1'b1;
         tdi_ff       <= 1'b1;
         tms_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         timer_ff     <= timer_in;
         hi_ff        <= hi_in;
         nrst_ff      <= nrst_in;
         ntrst_ff     <= ntrst_in;
         tdi_ff       <= tdi_in;
         tms_ff       <= tms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `JMS_ASSERT_IMPLY(a_pop_only_idle, plan_pop, state_ff == jms_pkg::BK_IDLE,
      "plan taken while a previous one is still running")
   `JMS_ASSERT_IMPLY(a_emit_has_room, emit, slot_free,
      "result written over a word that was not taken")
   `JMS_ASSERT_IMPLY(a_timer_bound, state_ff != jms_pkg::BK_IDLE, timer_ff <= half_m1,
      "half-period counter ran past its limit")
   `JMS_ASSERT_NEXT(a_exit_leaves_tms_low, state_ff == jms_pkg::BK_EXIT && step_done
      && bit_ff != 3'd0, !tms_ff && state_ff == jms_pkg::BK_IDLE,
      "update step did not return TMS low to idle")

endmodule
